// ===== src/qsvge_pkg.sv =====
`default_nettype none
package qsvge_pkg;

  localparam int OP_BITS   = 2;
  localparam int GATE_BITS = 3;
  localparam int Q_BITS    = 4;
  localparam int IDX_BITS  = 10;
  localparam int FLD_BITS  = 16;

  // operation codes
  localparam logic [OP_BITS-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_BITS-1:0] OP_GATE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_READ = 2'd2;
  localparam logic [OP_BITS-1:0] OP_NONE = 2'd3;

  // gate codes
  localparam logic [GATE_BITS-1:0] G_X    = 3'd0;
  localparam logic [GATE_BITS-1:0] G_Y    = 3'd1;
  localparam logic [GATE_BITS-1:0] G_Z    = 3'd2;
  localparam logic [GATE_BITS-1:0] G_H    = 3'd3;
  localparam logic [GATE_BITS-1:0] G_PH   = 3'd4;
  localparam logic [GATE_BITS-1:0] G_CNOT = 3'd5;

  // result kinds
  localparam logic [OP_BITS-1:0] RK_LOAD = 2'd0;
  localparam logic [OP_BITS-1:0] RK_GATE = 2'd1;
  localparam logic [OP_BITS-1:0] RK_READ = 2'd2;

  // 1/sqrt(2) in Q1.15
  localparam logic signed [FLD_BITS-1:0] INV_SQRT2 = 16'sd23170;

  typedef struct packed {
    logic [OP_BITS-1:0]          operation;
    logic [GATE_BITS-1:0]        gate;
    logic [Q_BITS-1:0]           qubit_a;
    logic [Q_BITS-1:0]           qubit_b;
    logic [IDX_BITS-1:0]         amp_index;
    logic signed [FLD_BITS-1:0]  load_re;
    logic signed [FLD_BITS-1:0]  load_im;
    logic signed [FLD_BITS-1:0]  phase_cos;
    logic signed [FLD_BITS-1:0]  phase_sin;
  } in_req_t;

  typedef struct packed {
    logic [OP_BITS-1:0]          result_kind;
    logic [IDX_BITS-1:0]         out_index;
    logic signed [FLD_BITS-1:0]  out_re;
    logic signed [FLD_BITS-1:0]  out_im;
    logic                        saturated;
  } out_res_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;   // capture request fields
    logic do_load;     // write loaded amplitude
    logic rd_issue;    // read amplitude at load/read index
    logic pair_rd0;    // read first amplitude of current pair
    logic pair_rd1;    // read second amplitude of current pair
    logic pair_wr0;    // write first result
    logic pair_wr1;    // write second result
    logic pair_next;   // advance pair counter
    logic compute;     // register pair arithmetic
    logic out_load;    // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic gate_skip;   // gate leaves state unchanged
    logic pair_skip;   // current counter value is not a pair base
    logic pair_last;   // counter at its final value
  } sts_t;

endpackage
`default_nettype wire

// ===== src/qsvge_ram.sv =====
`default_nettype none
module qsvge_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/qsvge_ctrl.sv =====
`default_nettype none
module qsvge_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  input  wire [1:0]          op,
  input  qsvge_pkg::sts_t    sts,
  output qsvge_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DISP  = 8'b0000_0010,
    S_RD0   = 8'b0000_0100,
    S_RD1   = 8'b0000_1000,
    S_CALC  = 8'b0001_0000,
    S_WR    = 8'b0010_0000,
    S_RDWT  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   wr1_r, wr1_nxt;
  logic   [1:0] op_r, op_nxt;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  // sequencing: each pair takes read, read, a read wait, compute, write-first, write-second
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr1_nxt       = wr1_r;
    op_nxt        = op_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_item = 1'b1;
          op_nxt        = op;
          if (op != qsvge_pkg::OP_NONE) state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (op_r)
          qsvge_pkg::OP_LOAD: begin
            cmd.do_load = 1'b1;
            cmd.rd_issue = 1'b1;
            state_nxt = S_RDWT;
          end
          qsvge_pkg::OP_READ: begin
            cmd.rd_issue = 1'b1;
            state_nxt = S_RDWT;
          end
          default: begin
            if (sts.gate_skip) state_nxt = S_DONE;
            else if (sts.pair_skip) begin
              cmd.pair_next = 1'b1;
              if (sts.pair_last) state_nxt = S_DONE;
            end else begin
              cmd.pair_rd0 = 1'b1;
              state_nxt = S_RD0;
            end
          end
        endcase
      end
      S_RD0: begin
        cmd.pair_rd1 = 1'b1;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.compute = 1'b1;
        wr1_nxt = 1'b0;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (!wr1_r) begin
          cmd.pair_wr0 = 1'b1;
          wr1_nxt = 1'b1;
        end else begin
          cmd.pair_wr1 = 1'b1;
          cmd.pair_next = 1'b1;
          state_nxt = sts.pair_last ? S_DONE : S_DISP;
        end
      end
      S_RDWT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wr1_r       <= 1'b0;
      op_r        <= qsvge_pkg::OP_LOAD;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wr1_r       <= wr1_nxt;
      op_r        <= op_nxt;
    end
  end

  // exactly one state active
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  // result appears only on leaving DONE
  a_outv: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result without completion");
  // no pair write in the same cycle as a new request
  a_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pair_wr0 || cmd.pair_wr1) |-> !(in_valid && in_ready))
    else $error("write during accept");

endmodule
`default_nettype wire

// ===== src/qsvge_dp.sv =====
`default_nettype none
module qsvge_dp #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_BITS   = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire [3:0]            cfg_data,
  input  wire                  cfg_we,
  input  qsvge_pkg::in_req_t   in_req,
  input  qsvge_pkg::cmd_t      cmd,
  output qsvge_pkg::sts_t      sts,
  output qsvge_pkg::out_res_t  out_res
);

  localparam int AW    = MAX_QUBITS;
  localparam int DEPTH = 1 << MAX_QUBITS;
  localparam int QW    = $clog2(MAX_QUBITS + 1);
  localparam int NW    = (QW > 4) ? QW : 4;
  localparam int PW    = 2 * AMP_BITS + 2;
  localparam logic signed [PW-1:0] HI = PW'((64'sd1 <<< (AMP_BITS - 1)) - 1);
  localparam logic signed [PW-1:0] LO = -HI - PW'(1);

  logic [3:0]            nq_r;
  qsvge_pkg::in_req_t    req_r;
  logic [AW-1:0]         cnt_r, cnt_nxt;
  logic                  sat_r, sat_nxt;
  logic [AW-1:0]         n_mask, a_mask, b_mask, idx_w;
  logic [NW-1:0]         n_eff;
  logic [AW-1:0]         pair_j;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [2*AMP_BITS-1:0] ram_wdata, ram_rdata;
  logic signed [AMP_BITS-1:0] r0_r, i0_r, r1_r, i1_r;
  logic                  got0_r, got1_r;
  logic signed [AMP_BITS-1:0] nr0_r, ni0_r, nr1_r, ni1_r;
  logic signed [AMP_BITS-1:0] nr0, ni0, nr1, ni1;
  logic                  pair_sat;
  logic signed [AMP_BITS-1:0] ld_re, ld_im;

  // clamp a wide value into the amplitude range
  function automatic logic [AMP_BITS:0] clip(input logic signed [PW-1:0] x);
    if (x > HI) return {1'b1, HI[AMP_BITS-1:0]};
    if (x < LO) return {1'b1, LO[AMP_BITS-1:0]};
    return {1'b0, x[AMP_BITS-1:0]};
  endfunction

  // round a Q.15 product: floor((x + 2^14) / 2^15)
  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] y;
    y = x + PW'(1 <<< 14);
    return y >>> 15;
  endfunction

  function automatic logic [AW-1:0] qmask(input logic [3:0] q, input logic [NW-1:0] n);
    if (q == 4'd0) return AW'(1);
    if (NW'(q) > n) return '0;
    return AW'(1) << (n - NW'(q));
  endfunction

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) nq_r <= 4'd10;
    else if (cfg_we) nq_r <= cfg_data;
  end

  always_comb begin
    if (nq_r == 4'd0) n_eff = NW'(1);
    else if (NW'(nq_r) > NW'(MAX_QUBITS)) n_eff = NW'(MAX_QUBITS);
    else n_eff = NW'(nq_r);
  end

  assign n_mask = AW'(({{AW{1'b0}}, 1'b1} << n_eff) - 1'b1);
  assign a_mask = qmask(req_r.qubit_a, n_eff);
  assign b_mask = qmask(req_r.qubit_b, n_eff);
  assign idx_w  = AW'(req_r.amp_index) & n_mask;
  assign pair_j = (req_r.gate == qsvge_pkg::G_CNOT) ? (cnt_r | b_mask) : (cnt_r | a_mask);

  // status to controller
  always_comb begin
    sts.gate_skip = (a_mask == '0) || (req_r.gate > qsvge_pkg::G_CNOT) ||
                    ((req_r.gate == qsvge_pkg::G_CNOT) && ((b_mask == '0) || (b_mask == a_mask)));
    if (req_r.gate == qsvge_pkg::G_CNOT)
      sts.pair_skip = ((cnt_r & a_mask) == '0) || ((cnt_r & b_mask) != '0);
    else
      sts.pair_skip = (cnt_r & a_mask) != '0;
    sts.pair_last = (cnt_r == n_mask);
  end

  // loaded value clamp (identity when the store is 16 bits or wider)
  always_comb begin
    logic [AMP_BITS:0] c;
    c = clip(PW'(req_r.load_re)); ld_re = c[AMP_BITS-1:0];
    c = clip(PW'(req_r.load_im)); ld_im = c[AMP_BITS-1:0];
  end

  // pair arithmetic: one shared multiply stage over registered operands
  always_comb begin
    logic [AMP_BITS:0] c0, c1, c2, c3;
    logic signed [PW-1:0] s0, s1, s2, s3;
    s0 = PW'(r0_r); s1 = PW'(i0_r); s2 = PW'(r1_r); s3 = PW'(i1_r);
    c0 = {1'b0, r0_r}; c1 = {1'b0, i0_r}; c2 = {1'b0, r1_r}; c3 = {1'b0, i1_r};
    case (req_r.gate)
      qsvge_pkg::G_X, qsvge_pkg::G_CNOT: begin
        c0 = {1'b0, r1_r}; c1 = {1'b0, i1_r}; c2 = {1'b0, r0_r}; c3 = {1'b0, i0_r};
      end
      qsvge_pkg::G_Y: begin
        c0 = clip(s3); c1 = clip(-s2); c2 = clip(-s1); c3 = clip(s0);
      end
      qsvge_pkg::G_Z: begin
        c2 = clip(-s2); c3 = clip(-s3);
      end
      qsvge_pkg::G_H: begin
        c0 = clip(rnd((s0 + s2) * PW'(qsvge_pkg::INV_SQRT2)));
        c1 = clip(rnd((s1 + s3) * PW'(qsvge_pkg::INV_SQRT2)));
        c2 = clip(rnd((s0 - s2) * PW'(qsvge_pkg::INV_SQRT2)));
        c3 = clip(rnd((s1 - s3) * PW'(qsvge_pkg::INV_SQRT2)));
      end
      qsvge_pkg::G_PH: begin
        c2 = clip(rnd(s2 * PW'(req_r.phase_cos) - s3 * PW'(req_r.phase_sin)));
        c3 = clip(rnd(s2 * PW'(req_r.phase_sin) + s3 * PW'(req_r.phase_cos)));
      end
      default: ;
    endcase
    nr0 = c0[AMP_BITS-1:0]; ni0 = c1[AMP_BITS-1:0];
    nr1 = c2[AMP_BITS-1:0]; ni1 = c3[AMP_BITS-1:0];
    pair_sat = c0[AMP_BITS] | c1[AMP_BITS] | c2[AMP_BITS] | c3[AMP_BITS];
  end

  // memory port control
  always_comb begin
    ram_we    = cmd.do_load | cmd.pair_wr0 | cmd.pair_wr1;
    ram_waddr = cmd.pair_wr1 ? pair_j : (cmd.pair_wr0 ? cnt_r : idx_w);
    if (cmd.pair_wr0)      ram_wdata = {nr0_r, ni0_r};
    else if (cmd.pair_wr1) ram_wdata = {nr1_r, ni1_r};
    else                   ram_wdata = {ld_re, ld_im};
    ram_raddr = cmd.pair_rd1 ? pair_j : (cmd.pair_rd0 ? cnt_r : idx_w);
  end

  qsvge_ram #(.WIDTH(2 * AMP_BITS), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt_nxt = cmd.load_item ? '0 : (cmd.pair_next ? cnt_r + 1'b1 : cnt_r);
  assign sat_nxt = cmd.load_item ? 1'b0 : (sat_r | (cmd.compute & pair_sat));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sat_r  <= 1'b0;
      got0_r <= 1'b0;
      got1_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      sat_r  <= sat_nxt;
      got0_r <= cmd.pair_rd0 | cmd.rd_issue;
      got1_r <= cmd.pair_rd1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) req_r <= in_req;
    if (got0_r) begin
      r0_r <= ram_rdata[2*AMP_BITS-1:AMP_BITS];
      i0_r <= ram_rdata[AMP_BITS-1:0];
    end
    if (got1_r) begin
      r1_r <= ram_rdata[2*AMP_BITS-1:AMP_BITS];
      i1_r <= ram_rdata[AMP_BITS-1:0];
    end
    if (cmd.compute) begin
      nr0_r <= nr0; ni0_r <= ni0; nr1_r <= nr1; ni1_r <= ni1;
    end
    if (cmd.out_load) begin
      if (req_r.operation == qsvge_pkg::OP_GATE) begin
        out_res.result_kind <= qsvge_pkg::RK_GATE;
        out_res.out_index   <= '0;
        out_res.out_re      <= '0;
        out_res.out_im      <= '0;
        out_res.saturated   <= sat_r;
      end else begin
        out_res.result_kind <= (req_r.operation == qsvge_pkg::OP_LOAD) ?
                               qsvge_pkg::RK_LOAD : qsvge_pkg::RK_READ;
        out_res.out_index   <= qsvge_pkg::IDX_BITS'(idx_w);
        // a load returns the value it stored; the RAM read sees the old word
        if (req_r.operation == qsvge_pkg::OP_LOAD) begin
          out_res.out_re    <= qsvge_pkg::FLD_BITS'(ld_re);
          out_res.out_im    <= qsvge_pkg::FLD_BITS'(ld_im);
        end else begin
          out_res.out_re    <= qsvge_pkg::FLD_BITS'(r0_r);
          out_res.out_im    <= qsvge_pkg::FLD_BITS'(i0_r);
        end
        out_res.saturated   <= 1'b0;
      end
    end
  end

  // pair counter stays within the active state size
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pair_next |-> ((cnt_r & ~n_mask) == '0))
    else $error("pair counter out of range");
  // second write goes to the partner address
  a_wr1: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pair_wr1 |-> (ram_waddr != cnt_r))
    else $error("pair write collides");
  // saturation only accumulates during gates
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sat_r) |-> $past(cmd.compute))
    else $error("saturation without compute");

endmodule
`default_nettype wire

// ===== src/qubit_state_vector_gate_engine.sv =====
`default_nettype none
// State-vector gate engine for up to MAX_QUBITS qubits, Q1.15 complex amplitudes.
// Input channel (in_valid/in_ready/in_req): one request loads an amplitude,
// reads one, or applies a gate (X, Y, Z, H, phase, CNOT) over the whole vector.
// Output channel (out_valid/out_ready/out_res): one result per request, except
// operation code three, which is dropped silently.
// Config channel (cfg_valid/cfg_ready/cfg_data): active qubit count, write while idle.
// Load and read pass through dispatch, a read wait and done before the result
// is registered; a gate that leaves the state unchanged goes from dispatch
// straight to done. A gate walks every index of the 2^n state: an index that
// is not a pair base is skipped in dispatch, and each amplitude pair takes two
// reads, a read wait, compute and two writes; the RAM's one read port and one
// write port set this order. One request is in flight at a time; the next is
// taken once the result register is empty.
// Reset: control clears, qubit count goes to 10; amplitudes are undefined until
// loaded. A stalled receiver holds the result register and the engine waits.
module qubit_state_vector_gate_engine #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_BITS   = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  qsvge_pkg::in_req_t   in_req,
  output logic                 out_valid,
  input  wire                  out_ready,
  output qsvge_pkg::out_res_t  out_res,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [3:0]            cfg_data
);

  qsvge_pkg::cmd_t cmd;
  qsvge_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  qsvge_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .op        (in_req.operation),
    .sts       (sts),
    .cmd       (cmd)
  );

  qsvge_dp #(.MAX_QUBITS(MAX_QUBITS), .AMP_BITS(AMP_BITS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_data (cfg_data),
    .cfg_we   (cfg_valid & cfg_ready),
    .in_req   (in_req),
    .cmd      (cmd),
    .sts      (sts),
    .out_res  (out_res)
  );

endmodule
`default_nettype wire
